// ----- sv/sbblur_pkg.sv -----
// Shared types and constants for the separable 3x3 binomial blur.
package sbblur_pkg;

    // Output queue sizing
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = 3;
    localparam int OUT_CNT_W = 4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

    // One column update: a new horizontal sum and what the row position implies
    typedef struct packed {
        logic [7:0] hs;        // horizontal sum for this column
        logic       has_above; // row >= 1: a vertical result for the row above
        logic       has_top;   // row >= 2: the older line store entry is valid
        logic       last_row;  // bottom row: also emit this row's output
        logic       eof;       // bottom-right column of the plane
        logic       last_op;   // final column update caused by its input pixel
    } col_op_t;

    // One output pixel
    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
        logic       eof;
    } result_t;

    // Up to two results produced by one column update, in order
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

endpackage

// ----- sv/sbblur_col_unit.sv -----
// Line store and vertical filter: read-modify-write of one column per cycle.
module sbblur_col_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     op_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0] op_addr,
    input  sbblur_pkg::col_op_t      op,
    output logic                     busy,
    output sbblur_pkg::result_pair_t res
);

    localparam int AW = $clog2(MAX_WIDTH);

    // Each entry holds {row y-2 sum, row y-1 sum} for one column
    logic [15:0] line_mem [MAX_WIDTH];

    logic [15:0]         rd_data_reg;
    logic                b_valid_reg;
    logic [AW-1:0]       b_addr_reg;
    sbblur_pkg::col_op_t b_op_reg;

    logic                wr_valid_reg;
    logic [AW-1:0]       wr_addr_reg;
    logic [15:0]         wr_data_reg;

    logic [15:0]         entry;
    logic [7:0]          mid;
    logic [7:0]          top;
    logic [7:0]          above;
    logic [9:0]          sum0;
    logic [9:0]          sum1;
    sbblur_pkg::result_t r0;
    sbblur_pkg::result_t r1;

    // Synchronous read
    always_ff @(posedge aclk) begin
        rd_data_reg <= line_mem[op_addr];
    end

    // Write back the shifted column
    always_ff @(posedge aclk) begin
        if (b_valid_reg) begin
            line_mem[b_addr_reg] <= {mid, b_op_reg.hs};
        end
    end

    // Read stage to compute stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg  <= 1'b0;
            wr_valid_reg <= 1'b0;
        end else begin
            b_valid_reg  <= op_valid;
            wr_valid_reg <= b_valid_reg;
        end
        b_addr_reg  <= op_addr;
        b_op_reg    <= op;
        wr_addr_reg <= b_addr_reg;
        wr_data_reg <= {mid, b_op_reg.hs};
    end

    // Forward the write that landed on the same edge as our read
    assign entry = (wr_valid_reg && (wr_addr_reg == b_addr_reg)) ? wr_data_reg : rd_data_reg;
    assign mid   = entry[7:0];
    assign top   = b_op_reg.has_top ? entry[15:8] : mid;
    assign above = b_op_reg.has_above ? mid : b_op_reg.hs;

    // Vertical [1 2 1] sums; bottom edge replicates the current row
    assign sum0 = {2'b00, top} + {1'b0, mid, 1'b0} + {2'b00, b_op_reg.hs};
    assign sum1 = {2'b00, above} + {2'b00, b_op_reg.hs} + {1'b0, b_op_reg.hs, 1'b0};

    assign r0.pixel = sum0[9:2];
    assign r0.last  = b_op_reg.last_op && !b_op_reg.last_row;
    assign r0.eof   = 1'b0;
    assign r1.pixel = sum1[9:2];
    assign r1.last  = b_op_reg.last_op;
    assign r1.eof   = b_op_reg.eof;

    // Pack results in emission order
    always_comb begin
        res.first  = r0;
        res.second = r1;
        res.count  = 2'd0;
        if (b_valid_reg) begin
            priority if (b_op_reg.has_above && b_op_reg.last_row) begin
                res.count = 2'd2;
            end else if (b_op_reg.has_above) begin
                res.count = 2'd1;
            end else if (b_op_reg.last_row) begin
                res.count = 2'd1;
                res.first = r1;
            end
        end
    end

    assign busy = b_valid_reg;

    // End of frame only on the final result of a column update
    a_eof_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && b_op_reg.eof) |-> (b_op_reg.last_op && b_op_reg.last_row))
        else $error("eof column update that is not the last of its pixel");

endmodule

// ----- sv/sbblur_out_fifo.sv -----
// Result queue: up to two pushes and one pop per cycle.
module sbblur_out_fifo (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  sbblur_pkg::result_pair_t push,
    output logic [sbblur_pkg::OUT_CNT_W-1:0] count,
    output logic                     m_valid,
    input  logic                     m_ready,
    output sbblur_pkg::result_t      m_data
);

    sbblur_pkg::result_t buf_mem [sbblur_pkg::OUT_DEPTH];

    logic [sbblur_pkg::OUT_PTR_W-1:0] wr_ptr_reg;
    logic [sbblur_pkg::OUT_PTR_W-1:0] rd_ptr_reg;
    logic [sbblur_pkg::OUT_CNT_W-1:0] count_reg;
    logic [sbblur_pkg::OUT_PTR_W-1:0] wr_ptr_next;
    logic [sbblur_pkg::OUT_PTR_W-1:0] wr_ptr_plus1;
    logic [sbblur_pkg::OUT_CNT_W-1:0] count_next;
    logic                             pop;

    assign pop          = m_valid && m_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + sbblur_pkg::OUT_PTR_W'(1);
    assign wr_ptr_next  = wr_ptr_reg + sbblur_pkg::OUT_PTR_W'(push.count);
    assign count_next   = count_reg + sbblur_pkg::OUT_CNT_W'(push.count)
                        - sbblur_pkg::OUT_CNT_W'(pop);

    // Storage
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            buf_mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            buf_mem[wr_ptr_plus1] <= push.second;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_reg + sbblur_pkg::OUT_PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    assign m_valid = (count_reg != '0);
    assign m_data  = buf_mem[rd_ptr_reg];
    assign count   = count_reg;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(count_reg) + 32'(push.count)) <= sbblur_pkg::OUT_DEPTH)
        else $error("result queue overflow");

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= sbblur_pkg::OUT_CNT_W'(sbblur_pkg::OUT_DEPTH))
        else $error("result queue level out of range");

endmodule

// ----- sv/separable_binomial_blur_3x3_top.sv -----
// Output path: the first result of a pixel passes the column unit's compute register and the result
// queue before it is offered; at a row end the last column's results follow once the pending update issues.
// Throughput: 1 pixel per cycle inside a row while the result queue has credit; a row end stalls the
// input for the second column update through the single line store port; on the last row each pixel
// makes two results and the one-per-cycle output port limits the pixel rate.
// Reset clears position, pixel history, queue and sizes (640 x 480); line store is not cleared.
module separable_binomial_blur_3x3_top #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_pixel_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_pixel_out,
    output logic                               m_last_of_burst,
    output logic                               m_end_of_frame,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sbblur_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                        cfg_data
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int RST_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam logic [AW-1:0] COL_LAST_RST = AW'(RST_W - 1);
    localparam logic [15:0]   ROW_LAST_RST = 16'd479;

    logic [AW-1:0]       col_last_reg;
    logic [15:0]         row_last_reg;
    logic [AW-1:0]       col_reg;
    logic [15:0]         row_reg;
    logic [15:0]         prev_reg;
    logic                pend_valid_reg;
    logic [AW-1:0]       pend_addr_reg;
    sbblur_pkg::col_op_t pend_op_reg;

    logic                in_xfer;
    logic                x_nz;
    logic                row_end;
    logic                last_row;
    logic [7:0]          left;
    logic [7:0]          midp;
    logic [7:0]          left2;
    logic [9:0]          hsum1;
    logic [9:0]          hsum2;
    sbblur_pkg::col_op_t op1;
    sbblur_pkg::col_op_t op2;
    logic [4:0]          need;
    logic                room;

    logic                issue_valid;
    logic [AW-1:0]       issue_addr;
    sbblur_pkg::col_op_t issue_op;

    logic                      busy;
    sbblur_pkg::result_pair_t  res;
    logic [sbblur_pkg::OUT_CNT_W-1:0] q_count;
    sbblur_pkg::result_t       q_data;

    // Position and horizontal [1 2 1] sums
    assign in_xfer  = s_valid && s_ready;
    assign x_nz     = (col_reg != '0);
    assign row_end  = (col_reg >= col_last_reg);
    assign last_row = (row_reg >= row_last_reg);
    assign left     = prev_reg[15:8];
    assign midp     = prev_reg[7:0];
    assign left2    = x_nz ? midp : s_pixel_in;
    assign hsum1    = {2'b00, left} + {1'b0, midp, 1'b0} + {2'b00, s_pixel_in};
    assign hsum2    = {2'b00, left2} + {2'b00, s_pixel_in} + {1'b0, s_pixel_in, 1'b0};

    // Column update for the previous column, and for this one at a row end
    always_comb begin
        op1.hs        = hsum1[9:2];
        op1.has_above = (row_reg != '0);
        op1.has_top   = (row_reg[15:1] != '0);
        op1.last_row  = last_row;
        op1.eof       = 1'b0;
        op1.last_op   = !row_end;
        op2           = op1;
        op2.hs        = hsum2[9:2];
        op2.eof       = last_row;
        op2.last_op   = 1'b1;
    end

    // Credit: queue must hold what is in flight plus one more update
    assign need    = 5'(q_count) + (busy ? 5'd2 : 5'd0) + 5'd2;
    assign room    = (need <= 5'(sbblur_pkg::OUT_DEPTH));
    assign s_ready = !pend_valid_reg && room;

    // Issue one column update per cycle, while the queue has credit
    always_comb begin
        issue_valid = 1'b0;
        issue_addr  = col_reg;
        issue_op    = op2;
        priority if (pend_valid_reg) begin
            issue_valid = room;
            issue_addr  = pend_addr_reg;
            issue_op    = pend_op_reg;
        end else if (in_xfer && x_nz) begin
            issue_valid = 1'b1;
            issue_addr  = col_reg - AW'(1);
            issue_op    = op1;
        end else if (in_xfer && row_end) begin
            issue_valid = 1'b1;
        end
    end

    // Pending second update at a row end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (pend_valid_reg && room) begin
            pend_valid_reg <= 1'b0;
        end else if (in_xfer && x_nz && row_end) begin
            pend_valid_reg <= 1'b1;
        end
        if (in_xfer) begin
            pend_addr_reg <= col_reg;
            pend_op_reg   <= op2;
        end
    end

    // Raster position and pixel history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            prev_reg <= '0;
        end else if (in_xfer) begin
            prev_reg <= x_nz ? {midp, s_pixel_in} : {s_pixel_in, s_pixel_in};
            if (row_end) begin
                col_reg <= '0;
                row_reg <= last_row ? 16'd0 : row_reg + 16'd1;
            end else begin
                col_reg <= col_reg + AW'(1);
            end
        end
    end

    // Size registers, kept as last column and last row
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_last_reg <= COL_LAST_RST;
            row_last_reg <= ROW_LAST_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sbblur_pkg::REG_FRAME_WIDTH: begin
                    if (cfg_data[11:0] == 12'd0) begin
                        col_last_reg <= '0;
                    end else if (32'(cfg_data[11:0]) > 32'(MAX_WIDTH)) begin
                        col_last_reg <= AW'(MAX_WIDTH - 1);
                    end else begin
                        col_last_reg <= AW'(cfg_data[11:0] - 12'd1);
                    end
                end
                sbblur_pkg::REG_FRAME_HEIGHT: begin
                    row_last_reg <= (cfg_data == 16'd0) ? 16'd0 : cfg_data - 16'd1;
                end
                default: begin
                end
            endcase
        end
    end

    sbblur_col_unit #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_col (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (issue_valid),
        .op_addr  (issue_addr),
        .op       (issue_op),
        .busy     (busy),
        .res      (res)
    );

    sbblur_out_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (res),
        .count   (q_count),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (q_data)
    );

    assign m_pixel_out     = q_data.pixel;
    assign m_last_of_burst = q_data.last;
    assign m_end_of_frame  = q_data.eof;

    a_pend_after_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && x_nz && row_end) |=> pend_valid_reg)
        else $error("row end did not queue the last column update");

    a_eof_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_of_frame) |-> m_last_of_burst)
        else $error("end of frame result not marked last of burst");

    a_no_issue_past_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        issue_valid |-> room)
        else $error("column update issued without queue space");

endmodule

// ----- dv/separable_binomial_blur_3x3_top_test.sv -----
// Self-checking testbench for the separable 3x3 binomial blur: streamed planes vs. a predictor.
module separable_binomial_blur_3x3_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W         = 2048;
    localparam int RANDOM_PIXELS = 400;
    localparam int SETTLE_CYCLES = 8;    // covers results still in the pipeline and pixels with no output
    localparam int HOLD_CYCLES   = 400;

    // Predicts the blurred pixels of each transfer and checks them in order
    class blur_scoreboard;
        logic [7:0]  hsum_older [MAX_W];
        logic [7:0]  hsum_newer [MAX_W];
        logic [7:0]  left_px = '0;
        logic [7:0]  mid_px = '0;
        int unsigned col = 0;
        int unsigned row = 0;
        logic [11:0] width_reg = 12'd640;
        logic [15:0] height_reg = 16'd480;
        sbblur_pkg::result_t due_pixels [$];
        sbblur_pkg::result_t burst [4];
        int          burst_len = 0;
        int unsigned pixels_in = 0;
        int unsigned pixels_checked = 0;
        int unsigned planes_done = 0;
        int unsigned errors = 0;

        function new();
            foreach (hsum_older[i]) begin
                hsum_older[i] = '0;
                hsum_newer[i] = '0;
            end
        endfunction

        function int unsigned eff_width();
            int unsigned w;
            w = width_reg;
            if (w == 0) w = 1;
            if (w > MAX_W) w = MAX_W;
            return w;
        endfunction

        function bit at_frame_start();
            return col == 0 && row == 0;
        endfunction

        function void note_config(logic [sbblur_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
            if (idx == sbblur_pkg::REG_FRAME_WIDTH) width_reg = data[11:0];
            else if (idx == sbblur_pkg::REG_FRAME_HEIGHT) height_reg = data;
        endfunction

        function void report(string what);
            errors++;
            if (errors <= 10) $display("ERROR @%0t: %s", $realtime, what);
        endfunction

        function void add_result(int unsigned v, bit eof);
            burst[burst_len].pixel = v[7:0];
            burst[burst_len].last  = 1'b0;
            burst[burst_len].eof   = eof;
            burst_len++;
        endfunction

        // New horizontal sum for column x: vertical sum for row y-1, and row y on the last row
        function void add_column(int unsigned x, int unsigned hs, int unsigned y,
                                 bit last_row, bit eof);
            int unsigned top, mid, above;
            mid = hsum_newer[x];
            top = (y >= 2) ? hsum_older[x] : mid;
            if (y >= 1) add_result((top + 2 * mid + hs) >> 2, 1'b0);
            if (last_row) begin
                above = (y >= 1) ? mid : hs;
                add_result((above + 3 * hs) >> 2, eof);
            end
            hsum_older[x] = mid[7:0];
            hsum_newer[x] = hs[7:0];
        endfunction

        // One accepted input pixel
        function void take_pixel(logic [7:0] p);
            int unsigned w, h, x, y, pv;
            bit row_end, last_row;
            w = eff_width();
            h = (height_reg == 0) ? 1 : height_reg;
            x = col;
            y = row;
            pv = p;
            row_end = (x >= w - 1);
            last_row = (y >= h - 1);
            burst_len = 0;
            if (x == 0) begin
                left_px = p;
                mid_px = p;
            end else begin
                add_column(x - 1, (left_px + 2 * mid_px + pv) >> 2, y, last_row, 1'b0);
                left_px = mid_px;
                mid_px = p;
            end
            // row end also closes the last column, edge replicated
            if (row_end) begin
                add_column(x, (left_px + 3 * pv) >> 2, y, last_row, last_row);
                col = 0;
                if (last_row) begin
                    row = 0;
                    planes_done++;
                end else begin
                    row = (y + 1) & 16'hFFFF;
                end
            end else begin
                col = x + 1;
            end
            if (burst_len > 0) burst[burst_len - 1].last = 1'b1;
            for (int i = 0; i < burst_len; i++) due_pixels.push_back(burst[i]);
            pixels_in++;
        endfunction

        // One output transfer against the oldest expectation
        function void check_output(logic [7:0] pix, logic last, logic eof);
            sbblur_pkg::result_t want;
            if (due_pixels.size() == 0) begin
                report($sformatf("unexpected output pixel=%0d last=%0b eof=%0b",
                                 pix, last, eof));
                return;
            end
            want = due_pixels.pop_front();
            pixels_checked++;
            if (want.pixel !== pix || want.last !== last || want.eof !== eof)
                report($sformatf("output %0d: expected pixel=%0d last=%0b eof=%0b, got %0d %0b %0b",
                                 pixels_checked, want.pixel, want.last, want.eof,
                                 pix, last, eof));
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_pixel_in = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [7:0]           m_pixel_out;
    logic                 m_last_of_burst;
    logic                 m_end_of_frame;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [sbblur_pkg::CFG_IDX_W-1:0] cfg_index = sbblur_pkg::REG_FRAME_WIDTH;
    logic [15:0]          cfg_data = '0;

    bit          steady = 1'b0;     // no idling on either side while set
    int unsigned sink_hold = 0;     // requested receiver hold-off, in cycles
    blur_scoreboard sb = new();

    separable_binomial_blur_3x3_top i_dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Output monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_output(m_pixel_out, m_last_of_burst, m_end_of_frame);
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (sink_hold != 0) begin
                m_ready <= 1'b0;
                repeat (sink_hold) @(posedge aclk);
                sink_hold = 0;
            end
            m_ready <= steady || ($urandom_range(99) >= 27);
        end
    end

    initial begin
        #3_000_000;
        $display("Timeout: %0d outputs still expected", sb.due_pixels.size());
        $display("separable_binomial_blur_3x3_top regression: fail");
        $finish;
    end

    // Pixel transfer; valid stays up for a back-to-back pixel
    task automatic send_pixel(input logic [7:0] p);
        if (!steady && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 27);
        end
        s_valid    <= 1'b1;
        s_pixel_in <= p;
        do @(posedge aclk); while (!s_ready);
        sb.take_pixel(p);
    endtask

    task automatic send_pixels(input int unsigned n);
        repeat (n) send_pixel(8'($urandom_range(255)));
    endtask

    // Keep sending until the plane wraps back to its first pixel
    task automatic finish_frame();
        do send_pixel(8'($urandom_range(255))); while (!sb.at_frame_start());
    endtask

    // Stop sending and let every expected output arrive
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.due_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Both size registers, back to back on the config channel
    task automatic program_size(input logic [15:0] w, input logic [15:0] h);
        cfg_valid <= 1'b1;
        cfg_index <= sbblur_pkg::REG_FRAME_WIDTH;
        cfg_data  <= w;
        do @(posedge aclk); while (!cfg_ready);
        sb.note_config(sbblur_pkg::REG_FRAME_WIDTH, w);
        cfg_index <= sbblur_pkg::REG_FRAME_HEIGHT;
        cfg_data  <= h;
        do @(posedge aclk); while (!cfg_ready);
        sb.note_config(sbblur_pkg::REG_FRAME_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(input logic [15:0] w, input logic [15:0] h);
        drain();
        program_size(w, h);
    endtask

    initial begin : stimulus
        int unsigned w, h, we, first_random, done;
        bit held;
        held = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // zero sizes act as a 1x1 plane
        set_frame(16'd0, 16'd0);
        send_pixel(8'hFF);
        // single row: outputs straight from the horizontal pass
        set_frame(16'd3, 16'd1);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h80);
        // single column
        set_frame(16'd1, 16'd3);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        // tallest height, then cut to two rows while in row 1 (four outputs at row end)
        set_frame(16'd3, 16'hFFFF);
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h00);
        set_frame(16'd3, 16'd2);
        finish_frame();
        // narrow the row and drop the height below the current row, mid-plane
        set_frame(16'd5, 16'd3);
        send_pixels(7);
        set_frame(16'd2, 16'd1);
        finish_frame();

        // random planes, some resized mid-plane
        first_random = sb.pixels_in;
        done = 0;
        while (done < RANDOM_PIXELS) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 0);
            h = $urandom_range(8, 0);
            we = (w == 0) ? 1 : w;
            steady = (done >= 150 && done < 300);
            set_frame({4'($urandom_range(15)), 12'(w)}, 16'(h));
            // receiver holds off while the sender keeps going, so the block backs up
            if (!held && we * h >= 24) begin
                sink_hold = HOLD_CYCLES;
                held = 1'b1;
            end
            if ($urandom_range(4) == 0 && we * h > 2) begin
                send_pixels($urandom_range(we * h - 1, 1));
                drain();
                // widening is only safe in row 0, where the line store contents are not used
                w = (sb.row == 0) ? $urandom_range(12, 1) : $urandom_range(sb.eff_width(), 1);
                program_size({4'($urandom_range(15)), 12'(w)}, 16'($urandom_range(8, 1)));
            end
            finish_frame();
            done = sb.pixels_in - first_random;
        end
        steady = 1'b0;

        // oversize width acts as the full line store; the row is cut short once under way
        set_frame(16'h0FFF, 16'd1);
        send_pixels(6);
        drain();
        program_size(16'd8, 16'd1);
        finish_frame();

        drain();
        repeat (16) @(posedge aclk);
        $display("Sent %0d pixels in %0d planes, checked %0d outputs", sb.pixels_in,
                 sb.planes_done, sb.pixels_checked);
        $display("Sizes from zero to an oversize width and 65535 high, with mid-plane resizes");
        if (sb.errors == 0) begin
            $display("separable_binomial_blur_3x3_top regression: pass");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("separable_binomial_blur_3x3_top regression: fail");
        end
        $finish;
    end

endmodule
